@@ rtl/lcdt_pkg.sv @@
// Shared types and constants for the LCD mode timing and register block.
package lcdt_pkg;

  localparam int VRAM_BYTES    = 8192;
  localparam int VRAM_AW       = $clog2(VRAM_BYTES);
  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;

  localparam logic [9:0] SEARCH_CYCLES   = 10'd80;
  localparam logic [9:0] TRANSFER_CYCLES = 10'd172;
  localparam logic [9:0] HBLANK_CYCLES   = 10'd204;
  localparam logic [9:0] LINE_CYCLES     = 10'd456;

  localparam logic [7:0] VISIBLE_LINE_CODE = 8'(VISIBLE_LINES);
  localparam logic [7:0] LAST_LINE_CODE    = 8'(LAST_LINE);

  // Bus map.
  localparam logic [2:0]  VRAM_PAGE     = 3'b100;
  localparam logic [15:0] ADDR_CONTROL  = 16'hFF40;
  localparam logic [15:0] ADDR_STAT     = 16'hFF41;
  localparam logic [15:0] ADDR_SCROLL_Y = 16'hFF42;
  localparam logic [15:0] ADDR_SCROLL_X = 16'hFF43;
  localparam logic [15:0] ADDR_LINE     = 16'hFF44;
  localparam logic [15:0] ADDR_LYC      = 16'hFF45;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_PAL0     = 16'hFF47;
  localparam logic [15:0] ADDR_PAL1     = 16'hFF48;
  localparam logic [15:0] ADDR_PAL2     = 16'hFF49;
  localparam logic [15:0] ADDR_WIN_Y    = 16'hFF4A;
  localparam logic [15:0] ADDR_WIN_X    = 16'hFF4B;

  localparam int LCD_ENABLE_BIT = 7;
  localparam int LYC_SOURCE_BIT = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  // Video RAM access issued at the accept edge.
  typedef struct packed {
    logic               wen;
    logic               ren;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         wdata;
  } vram_req_t;

  // Result of one item before the video RAM byte is merged in.
  typedef struct packed {
    logic       from_vram;
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_done;
    logic       frame_done;
    logic [1:0] mode_now;
    logic [7:0] line_now;
  } result_t;

  // Finished result held in the output queue.
  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_done;
    logic       frame_done;
    logic [1:0] mode_now;
    logic [7:0] line_now;
  } out_item_t;

endpackage

@@ rtl/lcd_mode_timing_and_registers.sv @@
// A result is registered in the register stage, then waits in the output queue until taken.
// Throughput: one transaction per cycle while in_stall is low, set by the single video RAM
// port; in_stall rises when the stage holds a result and the two-entry output queue is full.
// Reset (synchronous, active high) clears the display registers, puts the sequencer
// in sprite search at line zero and empties the pipeline; video RAM is not cleared.
module lcd_mode_timing_and_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        vblank_irq,
  output logic        stat_irq,
  output logic        line_done,
  output logic        frame_done,
  output logic [1:0]  mode_now,
  output logic [7:0]  line_now
);

  lcdt_pkg::vram_req_t vram_req;
  lcdt_pkg::result_t   stage_result;
  lcdt_pkg::out_item_t push_item;
  lcdt_pkg::out_item_t head_item;
  logic [7:0]          vram_rdata;
  logic                stage_valid, stage_valid_next;
  logic                stage_move;
  logic                can_push;
  logic                pop;
  logic                accept;

  assign pop        = out_valid && !out_stall;
  assign stage_move = stage_valid && can_push;
  assign in_stall   = stage_valid && !can_push;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    stage_valid_next = accept || (stage_valid && !stage_move);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  lcdt_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .address    (address),
    .write_data (write_data),
    .cycles     (cycles),
    .vram_req   (vram_req),
    .result     (stage_result)
  );

  lcdt_vram u_vram (
    .clk   (clk),
    .req   (vram_req),
    .rdata (vram_rdata)
  );

  // The RAM read data holds while the stage waits, since reads start only on accept.
  always_comb begin
    push_item.read_data  = stage_result.from_vram ? vram_rdata : stage_result.read_data;
    push_item.vblank_irq = stage_result.vblank_irq;
    push_item.stat_irq   = stage_result.stat_irq;
    push_item.line_done  = stage_result.line_done;
    push_item.frame_done = stage_result.frame_done;
    push_item.mode_now   = stage_result.mode_now;
    push_item.line_now   = stage_result.line_now;
  end

  lcdt_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (stage_move),
    .push_item  (push_item),
    .pop        (pop),
    .can_push   (can_push),
    .head_valid (out_valid),
    .head_item  (head_item)
  );

  assign read_data  = head_item.read_data;
  assign vblank_irq = head_item.vblank_irq;
  assign stat_irq   = head_item.stat_irq;
  assign line_done  = head_item.line_done;
  assign frame_done = head_item.frame_done;
  assign mode_now   = head_item.mode_now;
  assign line_now   = head_item.line_now;

endmodule

@@ rtl/lcdt_vram.sv @@
// Single-port video RAM with a registered read.
module lcdt_vram (
  input  logic                  clk,
  input  lcdt_pkg::vram_req_t   req,
  output logic [7:0]            rdata
);

  logic [7:0] mem [lcdt_pkg::VRAM_BYTES];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.ren) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ rtl/lcdt_regs.sv @@
// Display registers, mode sequencer and bus decode; registers the result of each item.
module lcdt_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          opcode,
  input  logic [15:0]         address,
  input  logic [7:0]          write_data,
  input  logic [7:0]          cycles,
  output lcdt_pkg::vram_req_t vram_req,
  output lcdt_pkg::result_t   result
);

  logic [7:0] control_bits, control_bits_next;
  logic [3:0] stat_sources, stat_sources_next;
  logic [7:0] scroll_y, scroll_y_next;
  logic [7:0] scroll_x, scroll_x_next;
  logic [7:0] line_compare, line_compare_next;
  logic [7:0] dma_page, dma_page_next;
  logic [7:0] raw_palettes [3];
  logic [7:0] raw_palettes_next [3];
  logic [7:0] window_y, window_y_next;
  logic [7:0] window_x, window_x_next;
  lcdt_pkg::mode_t lcd_mode, lcd_mode_next;
  logic [7:0] scan_line, scan_line_next;
  logic [9:0] mode_cycles, mode_cycles_next;

  lcdt_pkg::result_t result_next;
  logic [9:0]        cycle_sum;
  logic [7:0]        line_inc;
  logic              raise;
  logic              in_vram;

  assign cycle_sum = mode_cycles + {2'b00, cycles};
  assign line_inc  = scan_line + 8'd1;
  assign in_vram   = (address[15:13] == lcdt_pkg::VRAM_PAGE);

  always_comb begin
    control_bits_next    = control_bits;
    stat_sources_next    = stat_sources;
    scroll_y_next        = scroll_y;
    scroll_x_next        = scroll_x;
    line_compare_next    = line_compare;
    dma_page_next        = dma_page;
    raw_palettes_next[0] = raw_palettes[0];
    raw_palettes_next[1] = raw_palettes[1];
    raw_palettes_next[2] = raw_palettes[2];
    window_y_next        = window_y;
    window_x_next        = window_x;
    lcd_mode_next        = lcd_mode;
    scan_line_next       = scan_line;
    mode_cycles_next     = mode_cycles;
    raise                = 1'b0;
    result_next          = '0;
    vram_req.wen         = 1'b0;
    vram_req.ren         = 1'b0;
    vram_req.addr        = address[lcdt_pkg::VRAM_AW-1:0];
    vram_req.wdata       = write_data;

    case (lcdt_pkg::opcode_t'(opcode))
      lcdt_pkg::OP_TICK: begin
        if (control_bits[lcdt_pkg::LCD_ENABLE_BIT]) begin
          mode_cycles_next = cycle_sum;
          case (lcd_mode)
            lcdt_pkg::MODE_SEARCH: begin
              if (cycle_sum >= lcdt_pkg::SEARCH_CYCLES) begin
                lcd_mode_next    = lcdt_pkg::MODE_TRANSFER;
                mode_cycles_next = '0;
              end
            end
            lcdt_pkg::MODE_TRANSFER: begin
              if (cycle_sum >= lcdt_pkg::TRANSFER_CYCLES) begin
                lcd_mode_next         = lcdt_pkg::MODE_HBLANK;
                mode_cycles_next      = '0;
                result_next.line_done = 1'b1;
                raise                 = 1'b1;
              end
            end
            lcdt_pkg::MODE_HBLANK: begin
              if (cycle_sum >= lcdt_pkg::HBLANK_CYCLES) begin
                mode_cycles_next = '0;
                scan_line_next   = line_inc;
                raise            = 1'b1;
                if (line_inc == lcdt_pkg::VISIBLE_LINE_CODE) begin
                  result_next.frame_done = 1'b1;
                  lcd_mode_next          = lcdt_pkg::MODE_VBLANK;
                end else begin
                  lcd_mode_next = lcdt_pkg::MODE_SEARCH;
                end
              end
            end
            default: begin
              if (cycle_sum >= lcdt_pkg::LINE_CYCLES) begin
                mode_cycles_next = '0;
                scan_line_next   = line_inc;
                if (line_inc > lcdt_pkg::LAST_LINE_CODE) begin
                  scan_line_next = '0;
                  lcd_mode_next  = lcdt_pkg::MODE_SEARCH;
                  raise          = 1'b1;
                end
              end
            end
          endcase
        end
      end
      lcdt_pkg::OP_READ: begin
        if (in_vram) begin
          vram_req.ren          = accept;
          result_next.from_vram = 1'b1;
        end else begin
          case (address)
            lcdt_pkg::ADDR_CONTROL:  result_next.read_data = control_bits;
            lcdt_pkg::ADDR_STAT:     result_next.read_data = {1'b0, stat_sources,
                                       (line_compare == scan_line), lcd_mode};
            lcdt_pkg::ADDR_SCROLL_Y: result_next.read_data = scroll_y;
            lcdt_pkg::ADDR_SCROLL_X: result_next.read_data = scroll_x;
            lcdt_pkg::ADDR_LINE:     result_next.read_data = scan_line;
            lcdt_pkg::ADDR_LYC:      result_next.read_data = line_compare;
            lcdt_pkg::ADDR_DMA:      result_next.read_data = dma_page;
            lcdt_pkg::ADDR_PAL0:     result_next.read_data = raw_palettes[0];
            lcdt_pkg::ADDR_PAL1:     result_next.read_data = raw_palettes[1];
            lcdt_pkg::ADDR_PAL2:     result_next.read_data = raw_palettes[2];
            lcdt_pkg::ADDR_WIN_Y:    result_next.read_data = window_y;
            lcdt_pkg::ADDR_WIN_X:    result_next.read_data = window_x;
            default:                 result_next.read_data = '0;
          endcase
        end
      end
      lcdt_pkg::OP_WRITE: begin
        if (in_vram) begin
          vram_req.wen = accept;
        end else begin
          case (address)
            lcdt_pkg::ADDR_CONTROL:  control_bits_next    = write_data;
            lcdt_pkg::ADDR_STAT:     stat_sources_next    = write_data[6:3];
            lcdt_pkg::ADDR_SCROLL_Y: scroll_y_next        = write_data;
            lcdt_pkg::ADDR_SCROLL_X: scroll_x_next        = write_data;
            lcdt_pkg::ADDR_LYC:      line_compare_next    = write_data;
            lcdt_pkg::ADDR_DMA:      dma_page_next        = write_data;
            lcdt_pkg::ADDR_PAL0:     raw_palettes_next[0] = write_data;
            lcdt_pkg::ADDR_PAL1:     raw_palettes_next[1] = write_data;
            lcdt_pkg::ADDR_PAL2:     raw_palettes_next[2] = write_data;
            lcdt_pkg::ADDR_WIN_Y:    window_y_next        = write_data;
            lcdt_pkg::ADDR_WIN_X:    window_x_next        = write_data;
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Requests look at the mode and line that the transition has just entered.
    if (raise) begin
      result_next.vblank_irq = (lcd_mode_next == lcdt_pkg::MODE_VBLANK);
      result_next.stat_irq   =
        (stat_sources[lcdt_pkg::LYC_SOURCE_BIT] && (scan_line_next == line_compare)) ||
        ((lcd_mode_next != lcdt_pkg::MODE_TRANSFER) &&
         stat_sources[2'(lcd_mode_next)]);
    end
    result_next.mode_now = lcd_mode_next;
    result_next.line_now = scan_line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits    <= '0;
      stat_sources    <= '0;
      scroll_y        <= '0;
      scroll_x        <= '0;
      line_compare    <= '0;
      dma_page        <= '0;
      raw_palettes[0] <= '0;
      raw_palettes[1] <= '0;
      raw_palettes[2] <= '0;
      window_y        <= '0;
      window_x        <= '0;
      lcd_mode        <= lcdt_pkg::MODE_SEARCH;
      scan_line       <= '0;
      mode_cycles     <= '0;
    end else if (accept) begin
      control_bits    <= control_bits_next;
      stat_sources    <= stat_sources_next;
      scroll_y        <= scroll_y_next;
      scroll_x        <= scroll_x_next;
      line_compare    <= line_compare_next;
      dma_page        <= dma_page_next;
      raw_palettes[0] <= raw_palettes_next[0];
      raw_palettes[1] <= raw_palettes_next[1];
      raw_palettes[2] <= raw_palettes_next[2];
      window_y        <= window_y_next;
      window_x        <= window_x_next;
      lcd_mode        <= lcd_mode_next;
      scan_line       <= scan_line_next;
      mode_cycles     <= mode_cycles_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/lcdt_outq.sv @@
// Two-entry output queue that decouples the result channel from the register stage.
module lcdt_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdt_pkg::out_item_t push_item,
  input  logic                pop,
  output logic                can_push,
  output logic                head_valid,
  output lcdt_pkg::out_item_t head_item
);

  lcdt_pkg::out_item_t entries [2];
  logic       head, head_next;
  logic [1:0] count, count_next;
  logic       tail;

  // With two entries the tail is the head when empty or full, the other slot otherwise.
  assign tail       = head ^ count[0];
  assign can_push   = (count != 2'd2) || pop;
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[head];

  always_comb begin
    head_next  = head ^ pop;
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_item;
    end
  end

endmodule

@@ rtl/lcdt_checker.sv @@
// Port-level checks for the LCD mode timing block and the bind that attaches them.
module lcdt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       vblank_irq,
  input logic       line_done,
  input logic       frame_done,
  input logic [1:0] mode_now,
  input logic [7:0] line_now
);

  // A stalled result keeps its transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(line_now))
    else $error("stalled result changed");

  // The scanline never leaves the frame.
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_now <= lcdt_pkg::LAST_LINE_CODE)
    else $error("line beyond last line");

  // A finished frame always lands in vblank on the first invisible line.
  a_frame_vblank: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |->
      mode_now == lcdt_pkg::MODE_VBLANK && line_now == lcdt_pkg::VISIBLE_LINE_CODE)
    else $error("frame done outside vblank entry");

  // A vblank request comes only with vblank, and end of transfer only with hblank.
  a_irq_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!vblank_irq || mode_now == lcdt_pkg::MODE_VBLANK) &&
                  (!line_done || mode_now == lcdt_pkg::MODE_HBLANK))
    else $error("request reported in the wrong mode");

endmodule

bind lcd_mode_timing_and_registers lcdt_checker u_lcdt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_data  (read_data),
  .vblank_irq (vblank_irq),
  .line_done  (line_done),
  .frame_done (frame_done),
  .mode_now   (mode_now),
  .line_now   (line_now)
);

@@ bench/lcd_timing_checker.sv @@
// Scoreboard for the LCD timing block: predicts the result of each transaction and checks it.
module lcd_timing_checker
  import lcdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  cycles,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_data,
  input  logic        vblank_irq,
  input  logic        stat_irq,
  input  logic        line_done,
  input  logic        frame_done,
  input  logic [1:0]  mode_now,
  input  logic [7:0]  line_now,
  output int          err_count,
  output int          pending,
  output int          checked,
  output int          frames
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the display state.
  logic [7:0] vram_copy [VRAM_BYTES];
  logic [7:0] lcdc, scy, scx, lyc, dma_reg, wy, wx;
  logic [7:0] palettes [3];
  logic [3:0] sources;
  mode_t      cur_mode;
  logic [7:0] cur_line;
  logic [9:0] dots;

  out_item_t due_results [$];

  // Interrupt requests raised on entry into the mode now held in cur_mode.
  function automatic void entry_requests(inout logic vb, inout logic st);
    if (cur_mode == MODE_VBLANK) vb = 1'b1;
    if (sources[LYC_SOURCE_BIT] && cur_line == lyc) st = 1'b1;
    if (cur_mode != MODE_TRANSFER && sources[int'(cur_mode)]) st = 1'b1;
  endfunction

  function automatic out_item_t lcd_step(input logic [1:0] op, input logic [15:0] a,
                                        input logic [7:0] d, input logic [7:0] c);
    out_item_t r;
    logic vb, st;
    r = '0;
    vb = 1'b0;
    st = 1'b0;
    if (op == OP_TICK) begin
      if (lcdc[LCD_ENABLE_BIT]) begin
        dots = dots + 10'(c);
        // A long tick makes at most one transition; leftover cycles are dropped.
        case (cur_mode)
          MODE_SEARCH: begin
            if (dots >= SEARCH_CYCLES) begin
              cur_mode = MODE_TRANSFER;
              dots = '0;
            end
          end
          MODE_TRANSFER: begin
            if (dots >= TRANSFER_CYCLES) begin
              cur_mode = MODE_HBLANK;
              dots = '0;
              r.line_done = 1'b1;
              entry_requests(vb, st);
            end
          end
          MODE_HBLANK: begin
            if (dots >= HBLANK_CYCLES) begin
              dots = '0;
              cur_line = cur_line + 8'd1;
              if (cur_line == VISIBLE_LINE_CODE) begin
                r.frame_done = 1'b1;
                cur_mode = MODE_VBLANK;
              end else begin
                cur_mode = MODE_SEARCH;
              end
              entry_requests(vb, st);
            end
          end
          default: begin
            // Vblank lines step silently; only the wrap to line zero raises requests.
            if (dots >= LINE_CYCLES) begin
              dots = '0;
              cur_line = cur_line + 8'd1;
              if (cur_line > LAST_LINE_CODE) begin
                cur_line = '0;
                cur_mode = MODE_SEARCH;
                entry_requests(vb, st);
              end
            end
          end
        endcase
      end
    end else if (op == OP_READ) begin
      if (a[15:13] == VRAM_PAGE) begin
        r.read_data = vram_copy[a[VRAM_AW-1:0]];
      end else begin
        case (a)
          ADDR_CONTROL:  r.read_data = lcdc;
          ADDR_STAT:     r.read_data = {1'b0, sources, (lyc == cur_line), 2'(cur_mode)};
          ADDR_SCROLL_Y: r.read_data = scy;
          ADDR_SCROLL_X: r.read_data = scx;
          ADDR_LINE:     r.read_data = cur_line;
          ADDR_LYC:      r.read_data = lyc;
          ADDR_DMA:      r.read_data = dma_reg;
          ADDR_PAL0:     r.read_data = palettes[0];
          ADDR_PAL1:     r.read_data = palettes[1];
          ADDR_PAL2:     r.read_data = palettes[2];
          ADDR_WIN_Y:    r.read_data = wy;
          ADDR_WIN_X:    r.read_data = wx;
          default:       r.read_data = '0;
        endcase
      end
    end else if (op == OP_WRITE) begin
      if (a[15:13] == VRAM_PAGE) begin
        vram_copy[a[VRAM_AW-1:0]] = d;
      end else begin
        case (a)
          ADDR_CONTROL:  lcdc = d;
          ADDR_STAT:     sources = d[6:3];
          ADDR_SCROLL_Y: scy = d;
          ADDR_SCROLL_X: scx = d;
          ADDR_LYC:      lyc = d;
          ADDR_DMA:      dma_reg = d;
          ADDR_PAL0:     palettes[0] = d;
          ADDR_PAL1:     palettes[1] = d;
          ADDR_PAL2:     palettes[2] = d;
          ADDR_WIN_Y:    wy = d;
          ADDR_WIN_X:    wx = d;
          default: ;
        endcase
      end
    end
    r.vblank_irq = vb;
    r.stat_irq   = st;
    r.mode_now   = 2'(cur_mode);
    r.line_now   = cur_line;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      lcdc = '0;
      scy = '0;
      scx = '0;
      lyc = '0;
      dma_reg = '0;
      wy = '0;
      wx = '0;
      palettes = '{default: '0};
      sources = '0;
      cur_mode = MODE_SEARCH;
      cur_line = '0;
      dots = '0;
      due_results.delete();
      err_count = 0;
      checked = 0;
      frames = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no transaction waiting, expected none, %s %0h %0d %0d",
                   $time, "got data, mode and line", read_data, mode_now, line_now);
          err_count++;
        end else begin
          want = due_results.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("vblank_irq", 8'(want.vblank_irq), 8'(vblank_irq));
          check_field("stat_irq", 8'(want.stat_irq), 8'(stat_irq));
          check_field("line_done", 8'(want.line_done), 8'(line_done));
          check_field("frame_done", 8'(want.frame_done), 8'(frame_done));
          check_field("mode_now", 8'(want.mode_now), 8'(mode_now));
          check_field("line_now", want.line_now, line_now);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        want = lcd_step(opcode, address, write_data, cycles);
        if (want.frame_done) frames++;
        due_results.insert(due_results.size(), want);
      end
    end
    pending = due_results.size();
  end

endmodule

@@ bench/tb_lcd_mode_timing_and_registers.sv @@
// Top of the LCD timing testbench: clock, reset, stimulus, backpressure and the verdict.
module tb_lcd_mode_timing_and_registers;
  import lcdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1500;
  localparam logic [15:0] VRAM_BASE = {VRAM_PAGE, 13'h0000};

  typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_THIRD, STALL_LONG} stall_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  logic [1:0]  opcode = OP_TICK;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic [7:0]  cycles = '0;
  logic        in_stall, out_valid;
  logic [7:0]  read_data;
  logic        vblank_irq, stat_irq, line_done, frame_done;
  logic [1:0]  mode_now;
  logic [7:0]  line_now;
  int          err_count, pending, checked, frames;

  int burst_left = 0;
  int sent = 0;
  bit vram_touched [VRAM_BYTES];
  int vram_used [$];

  stall_style_t stall_style = STALL_NONE;
  int stall_phase_left = 0;
  int stall_tick = 0;

  lcd_mode_timing_and_registers dut (.*);
  lcd_timing_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure: phases of random length, each with its own stall shape.
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_phase_left = $urandom_range(20, 120);
    end
    stall_phase_left--;
    stall_tick++;
    case (stall_style)
      STALL_NONE:        out_stall <= 1'b0;
      STALL_COIN:        out_stall <= ($urandom_range(0, 1) == 1);
      STALL_EVERY_THIRD: out_stall <= (stall_tick % 3 == 0);
      default:           out_stall <= (stall_tick % 11 < 7);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic put_item(input logic [1:0] op, input logic [15:0] a, input logic [7:0] d,
                          input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= a;
    write_data <= d;
    cycles     <= c;
    do @(posedge clk); while (in_stall);
    burst_left--;
    sent++;
    if (op == OP_WRITE && a[15:13] == VRAM_PAGE && !vram_touched[a[VRAM_AW-1:0]]) begin
      vram_touched[a[VRAM_AW-1:0]] = 1'b1;
      vram_used.insert(vram_used.size(), int'(a[VRAM_AW-1:0]));
    end
    @(negedge clk);
  endtask

  initial begin
    int useful;
    int pick;
    int wait_cycles;
    logic [1:0]  op;
    logic [15:0] a;
    logic [7:0]  d, c;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The display starts disabled, so the first tick must change nothing.
    put_item(OP_TICK, 16'h0000, 8'h00, 8'hFF);
    put_item(OP_WRITE, VRAM_BASE, 8'hFF, 8'h00);
    put_item(OP_WRITE, 16'h9FFF, 8'h00, 8'hFF);
    put_item(OP_READ, VRAM_BASE, 8'h00, 8'h00);
    put_item(OP_READ, 16'h9FFF, 8'hFF, 8'hFF);
    put_item(OP_WRITE, ADDR_STAT, 8'hFF, 8'h00);
    put_item(OP_WRITE, ADDR_LYC, 8'h00, 8'h00);
    put_item(OP_WRITE, ADDR_DMA, 8'hA5, 8'h00);
    put_item(OP_WRITE, ADDR_LINE, 8'h55, 8'h00);
    put_item(OP_WRITE, 16'hA000, 8'h3C, 8'h00);
    put_item(OP_WRITE, 16'h7FFF, 8'hC3, 8'h00);
    put_item(OP_READ, ADDR_STAT, 8'h00, 8'h00);
    put_item(OP_READ, ADDR_LINE, 8'h00, 8'h00);
    put_item(OP_READ, ADDR_DMA, 8'h00, 8'h00);
    put_item(OP_READ, 16'hFFFF, 8'h00, 8'h00);
    put_item(OP_READ, 16'h0000, 8'h00, 8'h00);
    put_item(OP_NONE, 16'($urandom), 8'($urandom), 8'($urandom));
    put_item(OP_WRITE, ADDR_CONTROL, 8'h80, 8'h00);
    // Search ends exactly at its threshold; the long tick then ends transfer in one step.
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd0);
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd79);
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd1);
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd255);
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd203);
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd1);
    put_item(OP_WRITE, ADDR_CONTROL, 8'h00, 8'h00);
    put_item(OP_TICK, 16'h0000, 8'h00, 8'd255);
    put_item(OP_WRITE, ADDR_CONTROL, 8'h80, 8'h00);

    // Random part: mostly large ticks so that the sequencer runs through whole frames.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      a = 16'($urandom);
      d = 8'($urandom);
      c = 8'($urandom);
      if (pick < 70) begin
        op = OP_TICK;
        if ($urandom_range(0, 99) < 65) c = 8'($urandom_range(180, 255));
      end else if (pick < 80) begin
        op = OP_WRITE;
        a = ADDR_CONTROL + 16'($urandom_range(0, 11));
        if (a == ADDR_CONTROL) d[LCD_ENABLE_BIT] = ($urandom_range(0, 7) != 0);
        if (a == ADDR_LYC && $urandom_range(0, 4) != 0) d = 8'($urandom_range(0, LAST_LINE));
      end else if (pick < 90) begin
        op = OP_READ;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          a = ADDR_CONTROL + 16'($urandom_range(0, 11));
        end else if (pick < 9 && vram_used.size() > 0) begin
          a = VRAM_BASE | 16'(vram_used[$urandom_range(0, vram_used.size() - 1)]);
        end else if (a[15:13] == VRAM_PAGE) begin
          // Keep unmapped reads away from video RAM that may never have been written.
          a[15] = 1'b0;
        end
      end else if (pick < 96) begin
        op = OP_WRITE;
        a = VRAM_BASE | 16'($urandom_range(0, VRAM_BYTES - 1));
      end else if (pick < 98) begin
        op = OP_WRITE;
      end else begin
        op = OP_NONE;
      end
      put_item(op, a, d, c);
      if (op != OP_NONE) useful++;
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);

    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    $display("run covered %0d transactions, %0d results checked, %0d frames completed",
             sent, checked, frames);
    if (err_count + pending == 0) begin
      $display("tb_lcd_mode_timing_and_registers: clean");
    end else begin
      $display("tb_lcd_mode_timing_and_registers: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("tb_lcd_mode_timing_and_registers: errors");
    $finish;
  end

endmodule

@@ lcd_mode_timing_and_registers.f @@
rtl/lcdt_pkg.sv
rtl/lcdt_vram.sv
rtl/lcdt_regs.sv
rtl/lcdt_outq.sv
rtl/lcd_mode_timing_and_registers.sv
rtl/lcdt_checker.sv
bench/lcd_timing_checker.sv
bench/tb_lcd_mode_timing_and_registers.sv
